FILE: src/burst_adaptive_accel_ema_core_macros.svh
`ifndef BURST_ADAPTIVE_ACCEL_EMA_CORE_MACROS_SVH
`define BURST_ADAPTIVE_ACCEL_EMA_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BAEMA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define BAEMA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/baema_pkg.sv
package baema_pkg;

    localparam int GRAV_W   = 12;
    localparam int SPEED_W  = 16;
    localparam int LVL_W    = 16;
    localparam int LVL2_W   = 2 * LVL_W;
    localparam int ACC_W    = 18;
    localparam int SQ_W     = 34;
    localparam int MAG_W    = SQ_W + 2;
    localparam int TGT_W    = ACC_W + 8;
    localparam int EDIFF_W  = TGT_W + 2;
    localparam int EMA_W    = 32;
    localparam int OUT_W    = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 5;
    localparam int NSTAGE   = 5;

    localparam logic [GRAV_W-1:0]  GRAV_RESET       = 12'd2511;
    localparam logic [SPEED_W-1:0] STOP_SPEED_RESET = 16'd128;
    localparam logic [LVL_W-1:0]   LVL_STOP_RESET   = 16'd307;
    localparam logic [LVL_W-1:0]   LVL_MOVE_RESET   = 16'd205;

    typedef enum logic [2:0] {
        REG_OFFSET_X   = 3'd0,
        REG_OFFSET_Y   = 3'd1,
        REG_OFFSET_Z   = 3'd2,
        REG_GRAVITY    = 3'd3,
        REG_STOP_SPEED = 3'd4,
        REG_LVL_STOP   = 3'd5,
        REG_LVL_MOVE   = 3'd6
    } baema_reg_e;

    typedef struct packed {
        logic [GRAV_W-1:0]  gravity;
        logic [SPEED_W-1:0] stop_speed;
        logic [LVL_W-1:0]   lvl_stop;
        logic [LVL_W-1:0]   lvl_move;
    } baema_cfg_t;

    typedef struct packed {
        logic advance;
        logic update;
    } baema_ctl_t;

endpackage

FILE: src/baema_if.sv
interface baema_sample_if #(parameter int SAMPLE_BITS = 16);
    import baema_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic        [SPEED_W-1:0]     speed;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output speed, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input speed, output ready);
endinterface

interface baema_result_if;
    import baema_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered_accel;
    logic                    burst;
    logic                    moving;

    modport source (output valid, output filtered_accel, output burst, output moving,
                    input ready);
    modport sink   (input valid, input filtered_accel, input burst, input moving,
                    output ready);
endinterface

FILE: src/burst_adaptive_accel_ema_core.sv
// A result passes through the pipeline stages and then the output register; an output stall holds it.
// Throughput: one request per cycle while the output is not stalled; the loop that sets it is the EMA update.
// The whole pipeline advances only while the output register is empty or being taken.
// Reset (rst_n low, asynchronous): pipeline and output empty, EMA cleared to zero,
// registers at their documented reset values. No clearing pass is needed.
module burst_adaptive_accel_ema_core #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    baema_sample_if.sink                      sample,
    baema_result_if.source                    result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [baema_pkg::PADDR_W-1:0]     paddr,
    input  logic [baema_pkg::PDATA_W-1:0]     pwdata,
    output logic [baema_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import baema_pkg::*;

`include "burst_adaptive_accel_ema_core_macros.svh"

    localparam int RND_W = EMA_W + 1;

    logic signed [SAMPLE_BITS-1:0] offset_x, offset_y, offset_z;
    baema_cfg_t                    cfg;
    baema_ctl_t                    ctl;
    logic                          advance;
    logic                          accept;
    logic [NSTAGE:1]               stage_valid_reg;

    logic signed [ACC_W-1:0]       ax, ay, az;
    logic [SQ_W-1:0]               sq_x, sq_y, sq_z;
    logic signed [EMA_W-1:0]       ema;
    logic                          burst_s5, moving_s5;

    logic signed [RND_W-1:0]       rnd;
    logic signed [OUT_W-1:0]       filt_next;
    logic                          out_valid_reg;
    logic signed [OUT_W-1:0]       filt_reg;
    logic                          burst_reg;
    logic                          moving_reg;

    // Register file: offsets, gravity scale, stop speed and burst levels.
    baema_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .offset_z (offset_z),
        .cfg      (cfg)
    );

    // Advance every stage together whenever the output register can take a result;
    // a stall at the output freezes the whole pipeline, bubbles included.
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = advance;
    assign accept       = sample.valid && advance;

    // The EMA state may only move for a real request that leaves stage 4.
    assign ctl.advance = advance;
    assign ctl.update  = advance && stage_valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else if (advance)
            stage_valid_reg <= {stage_valid_reg[NSTAGE-1:1], accept};
    end

    // Three axis lanes: bias removal, gravity scaling, rounding, squaring.
    baema_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk     (clk),
        .advance (advance),
        .flip    (1'b0),
        .sample  (sample.accel_x),
        .offset  (offset_x),
        .gravity (cfg.gravity),
        .acc     (ax),
        .sq      (sq_x)
    );

    baema_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk     (clk),
        .advance (advance),
        .flip    (1'b0),
        .sample  (sample.accel_y),
        .offset  (offset_y),
        .gravity (cfg.gravity),
        .acc     (ay),
        .sq      (sq_y)
    );

    // Z lane reverses the sign: bias minus sample.
    baema_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .clk     (clk),
        .advance (advance),
        .flip    (1'b1),
        .sample  (sample.accel_z),
        .offset  (offset_z),
        .gravity (cfg.gravity),
        .acc     (az),
        .sq      (sq_z)
    );

    // Merge: magnitude against squared threshold, smoothing factor pick, EMA update.
    baema_merge #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg),
        .speed  (sample.speed),
        .ay     (ay),
        .sq_x   (sq_x),
        .sq_y   (sq_y),
        .sq_z   (sq_z),
        .ema    (ema),
        .burst  (burst_s5),
        .moving (moving_s5)
    );

    // Round the Q16.16 EMA to Q8.8 (half up) and saturate to 16 bits.
    always_comb
    begin
        rnd = (RND_W'(ema) + RND_W'(128)) >>> 8;
        if (rnd > RND_W'(32767))
            filt_next = 16'sh7FFF;
        else if (rnd < -RND_W'(32768))
            filt_next = -16'sh8000;
        else
            filt_next = rnd[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid_reg[NSTAGE];
    end

    // Payload: hold while the result waits to be taken.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            filt_reg   <= filt_next;
            burst_reg  <= burst_s5;
            moving_reg <= moving_s5;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.filtered_accel = filt_reg;
    assign result.burst          = burst_reg;
    assign result.moving         = moving_reg;

    // X and Z scaled values are only needed through their squares.
    logic unused_acc;
    assign unused_acc = ^{ax, az};

    `BAEMA_ASSERT_NEXT(a_accept_enters, accept, stage_valid_reg[1], "accepted request lost")
    `BAEMA_ASSERT_NEXT(a_stall_freezes, !advance, $stable(stage_valid_reg) && $stable(ema),
                       "pipeline moved during output stall")
    `BAEMA_ASSERT_NEXT(a_ema_only_on_update, !ctl.update, $stable(ema),
                       "EMA changed without a request")
    `BAEMA_ASSERT_ALWAYS(a_out_from_stage, !$rose(out_valid_reg) || $past(stage_valid_reg[NSTAGE]),
                         "result appeared without a request in the last stage")

endmodule

FILE: src/baema_cfg.sv
module baema_cfg #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [baema_pkg::PADDR_W-1:0]    paddr,
    input  logic [baema_pkg::PDATA_W-1:0]    pwdata,
    output logic [baema_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    output logic signed [SAMPLE_BITS-1:0]    offset_x,
    output logic signed [SAMPLE_BITS-1:0]    offset_y,
    output logic signed [SAMPLE_BITS-1:0]    offset_z,
    output baema_pkg::baema_cfg_t            cfg
);
    import baema_pkg::*;

    logic signed [SAMPLE_BITS-1:0] offset_x_reg;
    logic signed [SAMPLE_BITS-1:0] offset_y_reg;
    logic signed [SAMPLE_BITS-1:0] offset_z_reg;
    baema_cfg_t                    cfg_reg;
    baema_reg_e                    sel;
    logic                          wr_en;

    assign sel    = baema_reg_e'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            offset_z_reg       <= '0;
            cfg_reg.gravity    <= GRAV_RESET;
            cfg_reg.stop_speed <= STOP_SPEED_RESET;
            cfg_reg.lvl_stop   <= LVL_STOP_RESET;
            cfg_reg.lvl_move   <= LVL_MOVE_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_OFFSET_X:   offset_x_reg       <= pwdata[SAMPLE_BITS-1:0];
                REG_OFFSET_Y:   offset_y_reg       <= pwdata[SAMPLE_BITS-1:0];
                REG_OFFSET_Z:   offset_z_reg       <= pwdata[SAMPLE_BITS-1:0];
                REG_GRAVITY:    cfg_reg.gravity    <= pwdata[GRAV_W-1:0];
                REG_STOP_SPEED: cfg_reg.stop_speed <= pwdata[SPEED_W-1:0];
                REG_LVL_STOP:   cfg_reg.lvl_stop   <= pwdata[LVL_W-1:0];
                REG_LVL_MOVE:   cfg_reg.lvl_move   <= pwdata[LVL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_OFFSET_X:   prdata = PDATA_W'(offset_x_reg);
            REG_OFFSET_Y:   prdata = PDATA_W'(offset_y_reg);
            REG_OFFSET_Z:   prdata = PDATA_W'(offset_z_reg);
            REG_GRAVITY:    prdata = PDATA_W'(cfg_reg.gravity);
            REG_STOP_SPEED: prdata = PDATA_W'(cfg_reg.stop_speed);
            REG_LVL_STOP:   prdata = PDATA_W'(cfg_reg.lvl_stop);
            REG_LVL_MOVE:   prdata = PDATA_W'(cfg_reg.lvl_move);
            default:        prdata = '0;
        endcase
    end

    assign offset_x = offset_x_reg;
    assign offset_y = offset_y_reg;
    assign offset_z = offset_z_reg;
    assign cfg      = cfg_reg;

endmodule

FILE: src/baema_lane.sv
module baema_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 advance,
    input  logic                                 flip,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic signed [SAMPLE_BITS-1:0]        offset,
    input  logic [baema_pkg::GRAV_W-1:0]         gravity,
    output logic signed [baema_pkg::ACC_W-1:0]   acc,
    output logic [baema_pkg::SQ_W-1:0]           sq
);
    import baema_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + GRAV_W + 1;
    localparam int SHIFT  = SAMPLE_BITS - 4;

    logic signed [DIFF_W-1:0]    diff;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    rnd;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_d_reg;
    logic signed [2*ACC_W-1:0]   sq_full;
    logic [SQ_W-1:0]             sq_reg;

    // Z is mounted reversed: take the bias minus the sample there.
    always_comb
    begin
        if (flip)
            diff = DIFF_W'(offset) - DIFF_W'(sample);
        else
            diff = DIFF_W'(sample) - DIFF_W'(offset);
        prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, gravity}));
        rnd       = (prod_reg + (PROD_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
        acc_next  = rnd[ACC_W-1:0];
        sq_full   = acc_reg * acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            acc_reg   <= acc_next;
            acc_d_reg <= acc_reg;
            sq_reg    <= sq_full[SQ_W-1:0];
        end
    end

    assign acc = acc_d_reg;
    assign sq  = sq_reg;

endmodule

FILE: src/baema_merge.sv
module baema_merge #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  baema_pkg::baema_ctl_t                ctl,
    input  baema_pkg::baema_cfg_t                cfg,
    input  logic [baema_pkg::SPEED_W-1:0]        speed,
    input  logic signed [baema_pkg::ACC_W-1:0]   ay,
    input  logic [baema_pkg::SQ_W-1:0]           sq_x,
    input  logic [baema_pkg::SQ_W-1:0]           sq_y,
    input  logic [baema_pkg::SQ_W-1:0]           sq_z,
    output logic signed [baema_pkg::EMA_W-1:0]   ema,
    output logic                                 burst,
    output logic                                 moving
);
    import baema_pkg::*;

    localparam int    F     = ALPHA_FRAC_BITS;
    localparam int    PW    = EDIFF_W + F + 1;
    localparam longint ONE  = longint'(1) << F;
    localparam logic [F-1:0] ALPHA_STOP       = F'((2 * ONE + 200) / 400);
    localparam logic [F-1:0] ALPHA_STOP_BURST = F'((2 * ONE + 5) / 10);
    localparam logic [F-1:0] ALPHA_MOVE       = F'((4 * ONE + 25) / 50);
    localparam logic [F-1:0] ALPHA_MOVE_BURST = F'((6 * ONE + 20) / 40);

    logic                       mov1_reg, mov2_reg, mov3_reg, mov4_reg, mov5_reg;
    logic [LVL_W-1:0]           lvl1_reg;
    logic [LVL2_W-1:0]          lvl2_2_reg, lvl2_3_reg;
    logic [MAG_W-1:0]           mag;
    logic                       burst_next, burst4_reg, burst5_reg;
    logic [F-1:0]               alpha_next, alpha4_reg;
    logic signed [ACC_W-1:0]    ay4_reg;
    logic signed [TGT_W-1:0]    tgt;
    logic signed [EDIFF_W-1:0]  ediff;
    logic signed [PW-1:0]       step_full;
    logic signed [EMA_W-1:0]    ema_reg, ema_next;

    always_comb
    begin
        mag        = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
        burst_next = mag > MAG_W'(lvl2_3_reg);
        case ({mov3_reg, burst_next})
            2'b00:   alpha_next = ALPHA_STOP;
            2'b01:   alpha_next = ALPHA_STOP_BURST;
            2'b10:   alpha_next = ALPHA_MOVE;
            default: alpha_next = ALPHA_MOVE_BURST;
        endcase
        tgt       = $signed({ay4_reg, 8'd0});
        ediff     = EDIFF_W'(tgt) - $signed(ema_reg[EDIFF_W-1:0]);
        step_full = (PW'(ediff) * PW'($signed({1'b0, alpha4_reg}))
                     + (PW'(1) <<< (F - 1))) >>> F;
        ema_next  = ema_reg + step_full[EMA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            mov1_reg   <= speed >= cfg.stop_speed;
            lvl1_reg   <= (speed >= cfg.stop_speed) ? cfg.lvl_move : cfg.lvl_stop;
            mov2_reg   <= mov1_reg;
            lvl2_2_reg <= lvl1_reg * lvl1_reg;
            mov3_reg   <= mov2_reg;
            lvl2_3_reg <= lvl2_2_reg;
            mov4_reg   <= mov3_reg;
            burst4_reg <= burst_next;
            alpha4_reg <= alpha_next;
            ay4_reg    <= ay;
            mov5_reg   <= mov4_reg;
            burst5_reg <= burst4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ema_reg <= '0;
        else if (ctl.update)
            ema_reg <= ema_next;
    end

    assign ema    = ema_reg;
    assign burst  = burst5_reg;
    assign moving = mov5_reg;

endmodule
